FILE: hdl/cps_pkg.sv
// Shared types, constants and the descriptor comparator of the cell priority sorter.
package cps_pkg;

   localparam logic [0:0] CSR_COMPARATOR_MODE = 1'b0;
   localparam logic [0:0] CSR_SKOLEMS_LAST    = 1'b1;

   localparam logic [1:0] MODE_ROW  = 2'd1;
   localparam logic [1:0] MODE_DIAG = 2'd2;

   localparam logic [1:0] MaxArity = 2'd3;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOAD,
      OP_SORT,
      OP_SHIFT
   } op_type;

   // Sort keys of one descriptor, precomputed at load time.
   typedef struct packed {
      logic               eq;
      logic               sk;
      logic [7:0]         maxi;
      logic [7:0]         serial;
      logic [11:0]        id;
      logic signed [12:0] off;      // cell id minus symbol base
      logic               alleq;
      logic [9:0]         sumk;     // argument sum plus one, zero for no arguments
   } entry_type;

   typedef struct packed {
      op_type     op;
      logic       parity;
      logic [1:0] mode;
      logic       skl;
   } ctrl_type;

   // True when a must come after b.
   function automatic logic entry_gt(input entry_type a, input entry_type b,
                                     input logic [1:0] mode, input logic skl);
      logic res;
      if (a.eq != b.eq) begin
         res = a.eq;
      end else if (skl && (a.sk != b.sk)) begin
         res = a.sk;
      end else begin
         case (mode)
            MODE_ROW: begin
               if (a.off != b.off) res = (a.off > b.off);
               else res = (a.id > b.id);
            end
            MODE_DIAG: begin
               if (a.alleq != b.alleq) res = b.alleq;
               else if (a.off != b.off) res = (a.off > b.off);
               else res = (a.serial > b.serial);
            end
            default: begin
               if (a.maxi != b.maxi) res = (a.maxi > b.maxi);
               else if (a.alleq != b.alleq) res = b.alleq;
               else if (a.serial != b.serial) res = (a.serial > b.serial);
               else res = (a.sumk > b.sumk);
            end
         endcase
      end
      return res;
   endfunction

endpackage

FILE: hdl/cps_cell.sv
// One cell of the sorting chain: holds a descriptor, compares it with its right neighbor.
module cps_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  cps_pkg::ctrl_type    ctrl,
   input  logic                 pos_odd,
   input  logic                 load_here,
   input  cps_pkg::entry_type   new_entry,
   input  cps_pkg::entry_type   left_entry,
   input  logic                 left_swap,
   input  cps_pkg::entry_type   right_entry,
   input  logic                 right_valid,
   output cps_pkg::entry_type   entry,
   output logic                 valid,
   output logic                 swap
);

   cps_pkg::entry_type entry_ff, entry_in;
   logic               valid_ff, valid_in;
   logic               pair_left;

   assign pair_left = (pos_odd == ctrl.parity);
   assign swap = valid_ff && right_valid && pair_left &&
                 cps_pkg::entry_gt(entry_ff, right_entry, ctrl.mode, ctrl.skl);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (ctrl.op)
         cps_pkg::OP_LOAD: begin
            if (load_here) begin
               entry_in = new_entry;
               valid_in = 1'b1;
            end
         end
         cps_pkg::OP_SORT: begin
            // exchange with the partner of this phase
            if (swap) entry_in = right_entry;
            else if (!pair_left && left_swap) entry_in = left_entry;
         end
         cps_pkg::OP_SHIFT: begin
            entry_in = right_entry;
            valid_in = right_valid;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

FILE: hdl/cell_priority_sorter.sv
// Top level of the cell priority sorter: load, odd-even transposition sort, drain.
//
// Requests on the req_ channel carry one cell descriptor each. They are taken
// one per cycle while the block is loading; a descriptor beyond MAX_CELLS is
// dropped. The request flagged last_cell ends the load: req_ready then drops
// while the chain of cells sorts the n stored descriptors in n odd-even
// exchange phases (one phase per cycle, each pair of a phase compared in its
// left cell). The sorted ids then leave on the rsp_ channel, one per cycle
// while the receiver is ready, through an output register; the last one
// carries last_result and the position of the first Skolem cell, or n if
// there is none or Skolems are not placed last. When the receiver stalls,
// the chain holds and the output register keeps its value. Loading of the
// next run starts as soon as the last id sits in the output register. Reset
// empties the chain and clears both csr_ registers; csr_ writes take effect
// at once and are meant for idle periods.
module cell_priority_sorter #(
   parameter int MAX_CELLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [1:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_is_equality,
   input  logic        req_is_skolem,
   input  logic [7:0]  req_max_index,
   input  logic [7:0]  req_symbol_serial,
   input  logic [11:0] req_cell_id,
   input  logic [11:0] req_symbol_base,
   input  logic [1:0]  req_arity,
   input  logic [7:0]  req_arg0,
   input  logic [7:0]  req_arg1,
   input  logic [7:0]  req_arg2,
   input  logic        req_last_cell,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_sorted_cell_id,
   output logic [6:0]  rsp_first_skolem_position,
   output logic        rsp_last_result
);

   localparam int CntW = $clog2(MAX_CELLS + 1);

   typedef enum logic [1:0] {
      S_LOAD,
      S_SORT,
      S_DRAIN
   } state_type;

   state_type          state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [CntW-1:0]    phase_ff, phase_in;
   logic [CntW-1:0]    idx_ff, idx_in;
   logic [CntW-1:0]    pos_ff, pos_in;
   logic               found_ff, found_in;
   logic [1:0]         mode_ff;
   logic               skl_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [11:0]        rsp_id_ff, rsp_id_in;
   logic [6:0]         rsp_fsp_ff, rsp_fsp_in;
   logic               rsp_last_ff, rsp_last_in;

   cps_pkg::ctrl_type  ctrl;
   cps_pkg::entry_type new_entry;
   cps_pkg::entry_type cell_q [MAX_CELLS];
   logic [MAX_CELLS-1:0] cell_valid;
   logic [MAX_CELLS-1:0] cell_swap;
   logic [MAX_CELLS-1:0] load_sel;

   logic               req_fire, pop, pop_last, sk_hit;
   logic [1:0]         ar;
   logic [9:0]         sum;

   // descriptor keys
   always_comb begin
      ar = (req_arity > cps_pkg::MaxArity) ? cps_pkg::MaxArity : req_arity;
      sum = 10'(req_arg0) + ((ar >= 2'd2) ? 10'(req_arg1) : 10'd0)
          + ((ar == 2'd3) ? 10'(req_arg2) : 10'd0) + ((ar != 2'd0) ? 10'd1 : 10'd0);
      new_entry.eq     = req_is_equality;
      new_entry.sk     = req_is_skolem;
      new_entry.maxi   = req_max_index;
      new_entry.serial = req_symbol_serial;
      new_entry.id     = req_cell_id;
      new_entry.off    = $signed({1'b0, req_cell_id}) - $signed({1'b0, req_symbol_base});
      new_entry.alleq  = (ar <= 2'd1) ? 1'b1 :
                         (ar == 2'd2) ? (req_arg1 == req_arg0) :
                         ((req_arg1 == req_arg0) && (req_arg2 == req_arg0));
      new_entry.sumk   = (ar == 2'd0) ? 10'd0 : sum;
   end

   assign req_ready = (state_ff == S_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign pop       = (state_ff == S_DRAIN) && (idx_ff < count_ff) &&
                      (!rsp_valid_ff || rsp_ready);
   assign pop_last  = pop && (idx_ff == count_ff - CntW'(1));
   assign sk_hit    = skl_ff && cell_q[0].sk && !found_ff;

   always_comb begin
      ctrl.op     = cps_pkg::OP_HOLD;
      ctrl.parity = phase_ff[0];
      ctrl.mode   = mode_ff;
      ctrl.skl    = skl_ff;
      if (req_fire && (count_ff < CntW'(MAX_CELLS))) ctrl.op = cps_pkg::OP_LOAD;
      else if (state_ff == S_SORT) ctrl.op = cps_pkg::OP_SORT;
      else if (pop) ctrl.op = cps_pkg::OP_SHIFT;
   end

   genvar k;
   generate
      for (k = 0; k < MAX_CELLS; k++) begin : g_cell
         assign load_sel[k] = (count_ff == CntW'(k));
         if (k == 0 && k == MAX_CELLS - 1) begin : g_only
            cps_cell u_cell (
               .clock, .reset, .ctrl,
               .pos_odd(1'b0), .load_here(load_sel[k]), .new_entry,
               .left_entry('0), .left_swap(1'b0),
               .right_entry('0), .right_valid(1'b0),
               .entry(cell_q[k]), .valid(cell_valid[k]), .swap(cell_swap[k]));
         end else if (k == 0) begin : g_first
            cps_cell u_cell (
               .clock, .reset, .ctrl,
               .pos_odd(1'b0), .load_here(load_sel[k]), .new_entry,
               .left_entry('0), .left_swap(1'b0),
               .right_entry(cell_q[k+1]), .right_valid(cell_valid[k+1]),
               .entry(cell_q[k]), .valid(cell_valid[k]), .swap(cell_swap[k]));
         end else if (k == MAX_CELLS - 1) begin : g_last
            cps_cell u_cell (
               .clock, .reset, .ctrl,
               .pos_odd(k % 2 == 1), .load_here(load_sel[k]), .new_entry,
               .left_entry(cell_q[k-1]), .left_swap(cell_swap[k-1]),
               .right_entry('0), .right_valid(1'b0),
               .entry(cell_q[k]), .valid(cell_valid[k]), .swap(cell_swap[k]));
         end else begin : g_mid
            cps_cell u_cell (
               .clock, .reset, .ctrl,
               .pos_odd(k % 2 == 1), .load_here(load_sel[k]), .new_entry,
               .left_entry(cell_q[k-1]), .left_swap(cell_swap[k-1]),
               .right_entry(cell_q[k+1]), .right_valid(cell_valid[k+1]),
               .entry(cell_q[k]), .valid(cell_valid[k]), .swap(cell_swap[k]));
         end
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_fsp_in   = rsp_fsp_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (count_ff < CntW'(MAX_CELLS)) count_in = count_ff + CntW'(1);
               if (req_last_cell) begin
                  state_in = S_SORT;
                  phase_in = '0;
               end
            end
         end
         S_SORT: begin
            phase_in = phase_ff + CntW'(1);
            if (phase_ff == count_ff - CntW'(1)) begin
               state_in = S_DRAIN;
               idx_in   = '0;
               found_in = 1'b0;
            end
         end
         S_DRAIN: begin
            if (pop) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = cell_q[0].id;
               rsp_last_in  = pop_last;
               rsp_fsp_in   = '0;
               idx_in       = idx_ff + CntW'(1);
               if (sk_hit) begin
                  found_in = 1'b1;
                  pos_in   = idx_ff;
               end
               if (pop_last) begin
                  // report the first Skolem position, or the count if none is found or skl_ff is clear
                  rsp_fsp_in = found_ff ? 7'(pos_ff) : sk_hit ? 7'(idx_ff) : 7'(count_ff);
                  state_in   = S_LOAD;
                  count_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         phase_ff     <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 2'd0;
         skl_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == cps_pkg::CSR_COMPARATOR_MODE) mode_ff <= csr_wdata;
         if (csr_we && csr_index == cps_pkg::CSR_SKOLEMS_LAST) skl_ff <= csr_wdata[0];
      end
      pos_ff      <= pos_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_fsp_ff  <= rsp_fsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_sorted_cell_id        = rsp_id_ff;
   assign rsp_first_skolem_position = rsp_fsp_ff;
   assign rsp_last_result           = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_CELLS))
      else $error("cell count above capacity");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_DRAIN |-> $countones(cell_valid) == int'(count_ff))
      else $error("occupied cells do not match the count");

   a_drain_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN |-> $countones(cell_valid) == int'(count_ff - idx_ff))
      else $error("occupied cells do not match the remaining ids");

   a_fsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_fsp_ff == 7'd0)
      else $error("skolem position on a non-final id");

   a_sort_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SORT |-> cell_valid[0] && count_ff != '0)
      else $error("sort started on an empty chain");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking testbench for cell_priority_sorter: directed runs, store overflow, stalls, random runs.
module tb;

   localparam logic [1:0] MODE_DEFAULT = 2'd0;
   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int STORE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 150;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_SLACK  = 8;
   localparam int END_SLACK    = 200;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      logic        eq;
      logic        sk;
      logic [7:0]  maxi;
      logic [7:0]  serial;
      logic [11:0] id;
      logic [11:0] base;
      logic [1:0]  arity;
      logic [7:0]  arg0;
      logic [7:0]  arg1;
      logic [7:0]  arg2;
      logic        last;
   } cell_type;

   typedef struct {
      logic [11:0] id;
      logic [6:0]  skolem_pos;
      logic        last;
   } sorted_slot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = cps_pkg::CSR_COMPARATOR_MODE;
   logic [1:0]  csr_wdata = 2'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_is_equality = 1'b0;
   logic        req_is_skolem = 1'b0;
   logic [7:0]  req_max_index = 8'd0;
   logic [7:0]  req_symbol_serial = 8'd0;
   logic [11:0] req_cell_id = 12'd0;
   logic [11:0] req_symbol_base = 12'd0;
   logic [1:0]  req_arity = 2'd0;
   logic [7:0]  req_arg0 = 8'd0;
   logic [7:0]  req_arg1 = 8'd0;
   logic [7:0]  req_arg2 = 8'd0;
   logic        req_last_cell = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_sorted_cell_id;
   logic [6:0]  rsp_first_skolem_position;
   logic        rsp_last_result;

   // predictor state
   cell_type        loaded_cells[$];
   sorted_slot_type sorted_ids_due[$];
   logic [1:0]      mode_reg = MODE_DEFAULT;
   logic            skl_reg = 1'b0;

   int  mismatches = 0;
   int  cycle_count = 0;
   bit  req_eager = 1'b0;
   bit  rsp_eager = 1'b0;
   bit  rsp_hold_req = 1'b0;
   int  rsp_wait_left = 0;

   cell_priority_sorter #(.MAX_CELLS(STORE_DEPTH)) DUT (
      .clock                    (clock),
      .reset                    (reset),
      .csr_we                   (csr_we),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_is_equality          (req_is_equality),
      .req_is_skolem            (req_is_skolem),
      .req_max_index            (req_max_index),
      .req_symbol_serial        (req_symbol_serial),
      .req_cell_id              (req_cell_id),
      .req_symbol_base          (req_symbol_base),
      .req_arity                (req_arity),
      .req_arg0                 (req_arg0),
      .req_arg1                 (req_arg1),
      .req_arg2                 (req_arg2),
      .req_last_cell            (req_last_cell),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_sorted_cell_id       (rsp_sorted_cell_id),
      .rsp_first_skolem_position(rsp_first_skolem_position),
      .rsp_last_result          (rsp_last_result)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cell_priority_sorter test failed");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic bit args_match(input cell_type c);
      case (c.arity)
         2'd2:    return c.arg0 == c.arg1;
         2'd3:    return (c.arg0 == c.arg1) && (c.arg0 == c.arg2);
         default: return 1'b1;   // no argument or one argument
      endcase
   endfunction

   function automatic int arg_total(input cell_type c);
      int s;
      s = 0;
      if (c.arity == 2'd0) return -1;
      s += int'(c.arg0);
      if (c.arity >= 2'd2) s += int'(c.arg1);
      if (c.arity == 2'd3) s += int'(c.arg2);
      return s;
   endfunction

   function automatic int row_offset(input cell_type c);
      return int'(c.id) - int'(c.base);
   endfunction

   // True when a must be placed after b.
   function automatic bit goes_after(input cell_type a, input cell_type b);
      if (a.eq != b.eq) return a.eq;
      if (skl_reg && (a.sk != b.sk)) return a.sk;
      case (mode_reg)
         cps_pkg::MODE_ROW: begin
            if (row_offset(a) != row_offset(b)) return row_offset(a) > row_offset(b);
            return a.id > b.id;
         end
         cps_pkg::MODE_DIAG: begin
            if (args_match(a) != args_match(b)) return args_match(b);
            if (row_offset(a) != row_offset(b)) return row_offset(a) > row_offset(b);
            return a.serial > b.serial;
         end
         default: begin
            if (a.maxi != b.maxi) return a.maxi > b.maxi;
            if (args_match(a) != args_match(b)) return args_match(b);
            if (a.serial != b.serial) return a.serial > b.serial;
            return arg_total(a) > arg_total(b);
         end
      endcase
   endfunction

   // Store one accepted request while the store has room; on the last cell rank the set and queue the ids.
   function automatic void record_cell(input cell_type c);
      cell_type        ranked[$];
      sorted_slot_type slot;
      int              j;
      int              first_sk;
      if (loaded_cells.size() < STORE_DEPTH) loaded_cells.push_back(c);
      if (!c.last) return;
      foreach (loaded_cells[i]) begin
         j = ranked.size();
         while (j > 0 && goes_after(ranked[j-1], loaded_cells[i])) j--;
         ranked.insert(j, loaded_cells[i]);
      end
      first_sk = ranked.size();
      if (skl_reg) begin
         for (int i = ranked.size() - 1; i >= 0; i--)
            if (ranked[i].sk) first_sk = i;
      end
      foreach (ranked[i]) begin
         slot.id         = ranked[i].id;
         slot.last       = (i == ranked.size() - 1);
         slot.skolem_pos = slot.last ? 7'(first_sk) : 7'd0;
         sorted_ids_due.push_back(slot);
      end
      loaded_cells.delete();
   endfunction

   // ---------------- checker ----------------

   always @(posedge clock) begin
      sorted_slot_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_ids_due.size() == 0) begin
            $error("unexpected result: sorted_cell_id %0d", rsp_sorted_cell_id);
            mismatches++;
         end else begin
            want = sorted_ids_due.pop_front();
            if (rsp_sorted_cell_id !== want.id) begin
               $error("sorted_cell_id: expected %0d, actual %0d", want.id, rsp_sorted_cell_id);
               mismatches++;
            end
            if (rsp_first_skolem_position !== want.skolem_pos) begin
               $error("first_skolem_position: expected %0d, actual %0d",
                      want.skolem_pos, rsp_first_skolem_position);
               mismatches++;
            end
            if (rsp_last_result !== want.last) begin
               $error("last_result: expected %0d, actual %0d", want.last, rsp_last_result);
               mismatches++;
            end
         end
      end
   end

   // ---------------- idling ----------------

   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // Receiver: random stalls, plus a long hold-off on request from a test.
   always @(negedge clock) begin
      if (rsp_hold_req) begin
         rsp_hold_req = 1'b0;
         rsp_wait_left = LONG_HOLD;
      end
      if (rsp_wait_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_wait_left--;
      end else if (!rsp_eager && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_wait_left = idle_length() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------- stimulus helpers ----------------

   function automatic cell_type make_cell(input logic eq, input logic sk, input logic [7:0] maxi,
                                          input logic [7:0] serial, input logic [11:0] id,
                                          input logic [11:0] base, input logic [1:0] arity,
                                          input logic [7:0] a0, input logic [7:0] a1,
                                          input logic [7:0] a2, input logic last);
      cell_type c;
      c.eq = eq; c.sk = sk; c.maxi = maxi; c.serial = serial; c.id = id; c.base = base;
      c.arity = arity; c.arg0 = a0; c.arg1 = a1; c.arg2 = a2; c.last = last;
      return c;
   endfunction

   // Tight cells draw keys from small ranges so that ties reach the later keys.
   function automatic cell_type random_cell(input bit tight, input logic last);
      cell_type c;
      c.eq    = ($urandom_range(0, 4) == 0);
      c.sk    = ($urandom_range(0, 2) == 0);
      c.arity = 2'($urandom_range(0, 3));
      c.last  = last;
      if (tight) begin
         c.maxi   = 8'($urandom_range(0, 2));
         c.serial = 8'($urandom_range(0, 2));
         c.id     = 12'($urandom_range(0, 7));
         c.base   = 12'($urandom_range(0, 7));
         c.arg0   = 8'($urandom_range(0, 2));
         c.arg1   = 8'($urandom_range(0, 2));
         c.arg2   = 8'($urandom_range(0, 2));
      end else begin
         c.maxi   = 8'($urandom);
         c.serial = 8'($urandom);
         c.id     = 12'($urandom);
         c.base   = 12'($urandom);
         c.arg0   = 8'($urandom);
         c.arg1   = 8'($urandom);
         c.arg2   = 8'($urandom);
      end
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_cell(input cell_type c);
      int gap;
      gap = (req_eager || $urandom_range(0, 2) != 0) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_is_equality   <= c.eq;
      req_is_skolem     <= c.sk;
      req_max_index     <= c.maxi;
      req_symbol_serial <= c.serial;
      req_cell_id       <= c.id;
      req_symbol_base   <= c.base;
      req_arity         <= c.arity;
      req_arg0          <= c.arg0;
      req_arg1          <= c.arg1;
      req_arg2          <= c.arg2;
      req_last_cell     <= c.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      record_cell(c);
      @(negedge clock);
   endtask

   task automatic send_run(input int len, input bit tight);
      for (int k = 0; k < len; k++) send_cell(random_cell(tight, k == len - 1));
   endtask

   // Stop offering requests and wait until every queued id has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sorted_ids_due.size() != 0) @(negedge clock);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   task automatic apply_settings(input logic [1:0] mode, input logic skl);
      logic spare_bit;
      spare_bit = 1'($urandom_range(0, 1));
      csr_we    <= 1'b1;
      csr_index <= cps_pkg::CSR_COMPARATOR_MODE;
      csr_wdata <= mode;
      @(negedge clock);
      csr_index <= cps_pkg::CSR_SKOLEMS_LAST;
      csr_wdata <= {spare_bit, skl};
      @(negedge clock);
      csr_we   <= 1'b0;
      mode_reg = mode;
      skl_reg  = skl;
   endtask

   // ---------------- tests ----------------

   task automatic test_field_extremes();
      wait_drained();
      apply_settings(MODE_DEFAULT, 1'b1);
      // both flags set, all fields but the symbol base at their maximum
      send_cell(make_cell(1, 1, 8'hFF, 8'hFF, 12'hFFF, 12'h000, 2'd3,
                          8'hFF, 8'hFF, 8'hFF, 0));
      // no arguments, row offset at its most negative
      send_cell(make_cell(0, 0, 8'h00, 8'h00, 12'h000, 12'hFFF, 2'd0,
                          8'h00, 8'h00, 8'h00, 0));
      // one argument counts as all equal
      send_cell(make_cell(0, 1, 8'h00, 8'h00, 12'h001, 12'h001, 2'd1,
                          8'hAA, 8'h55, 8'h55, 0));
      send_cell(make_cell(0, 0, 8'h00, 8'h00, 12'h002, 12'h000, 2'd2,
                          8'h07, 8'h07, 8'h09, 0));
      send_cell(make_cell(0, 0, 8'h00, 8'h00, 12'h003, 12'h000, 2'd3,
                          8'h01, 8'h02, 8'h03, 1));
      // single-cell run whose only cell is Skolem
      send_cell(make_cell(0, 1, 8'h80, 8'h80, 12'h800, 12'h7FF, 2'd2,
                          8'h55, 8'hAA, 8'hAA, 1));
   endtask

   task automatic mode_run(input logic [1:0] mode, input logic skl);
      wait_drained();
      apply_settings(mode, skl);
      send_cell(make_cell(1, 1, 8'h01, 8'h01, 12'h010, 12'h00F, 2'd2,
                          8'h01, 8'h01, 8'h00, 0));
      send_run(3, 1'b1);
   endtask

   task automatic test_comparator_modes();
      mode_run(MODE_DEFAULT, 1'b1);
      mode_run(cps_pkg::MODE_ROW, 1'b0);
      mode_run(cps_pkg::MODE_DIAG, 1'b1);
      mode_run(MODE_SPARE, 1'b0);   // spare mode falls back to the default keys
   endtask

   // Overflow the store; the dropped final request still starts the sort.
   task automatic test_store_full();
      wait_drained();
      apply_settings(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      send_run(STORE_DEPTH + 2, 1'($urandom_range(0, 1)));
   endtask

   // Hold the receiver off while two runs are offered back to back.
   task automatic test_output_hold();
      wait_drained();
      req_eager = 1'b1;
      rsp_hold_req = 1'b1;
      send_run(12, 1'b1);
      send_run(10, 1'b0);
      wait_drained();
      req_eager = 1'b0;
   endtask

   task automatic test_random_runs();
      int items;
      int len;
      int pick;
      items = 0;
      while (items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_drained();
            apply_settings(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         end
         pick = $urandom_range(0, 19);
         if (pick < 16)      len = $urandom_range(1, 8);
         else if (pick < 19) len = $urandom_range(9, 24);
         else                len = $urandom_range(40, STORE_DEPTH);
         req_eager = ($urandom_range(0, 4) == 0);
         rsp_eager = ($urandom_range(0, 4) == 0);
         send_run(len, $urandom_range(0, 3) != 0);
         items += len;
      end
      req_eager = 1'b0;
      rsp_eager = 1'b0;
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_field_extremes();
      test_comparator_modes();
      test_store_full();
      test_output_hold();
      test_random_runs();
      wait_drained();
      repeat (END_SLACK) @(negedge clock);
      if (mismatches == 0) begin
         $display("cell_priority_sorter test passed");
      end else begin
         $display("cell_priority_sorter test failed");
      end
      $finish;
   end

endmodule
